// ----- rtl/core/bdh_pkg.sv -----
// Shared types and constants for the banded density histogram.
// Used by every module under rtl/core; depends on nothing.
`timescale 1ns / 1ps

package bdh_pkg;

   localparam int Q_W        = 17;
   localparam int SEL_W      = 5;
   localparam int REQ_CODE_W = 2;
   localparam int REQ_USER_W = REQ_CODE_W + 1;
   localparam int OUT_IDX_W  = 5;
   localparam int OUT_CNT_W  = 40;
   localparam int CSR_IDX_W  = 2;
   localparam int QUEUE_DEPTH = 2;

   localparam int REQ_DATA_W = ((Q_W + SEL_W + 7) / 8) * 8;
   localparam int RSP_BITS   = OUT_IDX_W + 4 * OUT_CNT_W;
   localparam int RSP_DATA_W = ((RSP_BITS + 7) / 8) * 8;

   localparam logic [Q_W-1:0] BAND_LOW_RESET  = 17'd0;
   localparam logic [Q_W-1:0] BAND_HIGH_RESET = 17'd65536;

   localparam logic [CSR_IDX_W-1:0] CSR_BAND_LOW  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BAND_HIGH = 2'd1;

   typedef enum logic [REQ_CODE_W-1:0] {
      REQ_SAMPLE = 2'd0,
      REQ_READ   = 2'd1,
      REQ_CLEAR  = 2'd2
   } req_code_type;

   typedef enum logic [1:0] {
      OP_COUNT,
      OP_READ,
      OP_CLEAR
   } op_type;

   typedef struct packed {
      op_type op;
      logic   at_low;
      logic   at_high;
   } entry_type;

   typedef enum logic [1:0] {
      FR_IDLE,
      FR_DIV,
      FR_PUSH
   } front_state_type;

   typedef enum logic {
      BK_IDLE,
      BK_UPDATE
   } back_state_type;

endpackage

// ----- rtl/core/bdh_front.sv -----
// Front end: takes request beats, classifies them and finds the bin of a sample
// with a restoring divider, one quotient bit a cycle. Depends on bdh_pkg.
`timescale 1ns / 1ps

module bdh_front #(
   parameter int BIN_COUNT = 20
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [bdh_pkg::REQ_CODE_W-1:0]   req_code,
   input  logic                             in_lattice,
   input  logic [bdh_pkg::Q_W-1:0]          density,
   input  logic [bdh_pkg::SEL_W-1:0]        bin_select,
   input  logic [bdh_pkg::Q_W-1:0]          band_low,
   input  logic [bdh_pkg::Q_W-1:0]          band_high,
   output logic                             push_valid,
   input  logic                             push_ready,
   output bdh_pkg::entry_type               push_entry,
   output logic [$clog2(BIN_COUNT)-1:0]     push_idx
);

   localparam int IDX_W  = $clog2(BIN_COUNT);
   localparam int DIV_W  = bdh_pkg::Q_W + IDX_W;
   localparam int STEP_W = $clog2(IDX_W + 1);

   bdh_pkg::front_state_type state_ff, state_in;
   bdh_pkg::op_type          op_ff, op_in;
   logic [IDX_W-1:0]         idx_ff, idx_in;
   logic                     at_low_ff, at_low_in;
   logic                     at_high_ff, at_high_in;
   logic [DIV_W-1:0]         rem_ff, rem_in;
   logic [DIV_W-1:0]         dsh_ff, dsh_in;
   logic [IDX_W-1:0]         quo_ff, quo_in;
   logic [STEP_W-1:0]        cnt_ff, cnt_in;

   logic                     accept;
   logic                     num_neg, den_neg;
   logic [bdh_pkg::Q_W-1:0]  num_mag, den_mag;
   logic                     bin_zero, bin_top, need_div;
   logic                     div_ge;
   logic [IDX_W-1:0]         sel_idx;

   assign accept = req_valid && req_ready;

   always_comb begin
      num_neg  = density < band_low;
      num_mag  = num_neg ? band_low - density : density - band_low;
      den_neg  = band_high < band_low;
      den_mag  = den_neg ? band_low - band_high : band_high - band_low;
      bin_zero = (band_high == band_low) || (num_mag == '0) || (num_neg != den_neg);
      bin_top  = num_mag >= den_mag;
      need_div = (req_code == bdh_pkg::REQ_SAMPLE) && in_lattice && !bin_zero && !bin_top;
      sel_idx  = (int'(bin_select) >= BIN_COUNT) ? IDX_W'(BIN_COUNT - 1) : IDX_W'(bin_select);
      div_ge   = rem_ff >= dsh_ff;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         bdh_pkg::FR_IDLE: begin
            if (accept) begin
               state_in = need_div ? bdh_pkg::FR_DIV : bdh_pkg::FR_PUSH;
            end
         end
         bdh_pkg::FR_DIV: begin
            if (cnt_ff == '0) begin
               state_in = bdh_pkg::FR_PUSH;
            end
         end
         bdh_pkg::FR_PUSH: begin
            if (accept) begin
               state_in = need_div ? bdh_pkg::FR_DIV : bdh_pkg::FR_PUSH;
            end else if (push_ready) begin
               state_in = bdh_pkg::FR_IDLE;
            end
         end
         default: state_in = bdh_pkg::FR_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      req_ready  = 1'b0;
      push_valid = 1'b0;
      case (state_ff)
         bdh_pkg::FR_IDLE: req_ready = 1'b1;
         bdh_pkg::FR_PUSH: begin
            req_ready  = push_ready;
            push_valid = 1'b1;
         end
         default: begin
            req_ready  = 1'b0;
            push_valid = 1'b0;
         end
      endcase
   end

   // datapath
   always_comb begin
      op_in      = op_ff;
      idx_in     = idx_ff;
      at_low_in  = at_low_ff;
      at_high_in = at_high_ff;
      rem_in     = rem_ff;
      dsh_in     = dsh_ff;
      quo_in     = quo_ff;
      cnt_in     = cnt_ff;
      if (accept) begin
         at_low_in  = density <= band_low;
         at_high_in = density >= band_high;
         rem_in     = DIV_W'(num_mag * BIN_COUNT);
         dsh_in     = DIV_W'(den_mag) << (IDX_W - 1);
         quo_in     = '0;
         cnt_in     = STEP_W'(IDX_W - 1);
         case (req_code)
            bdh_pkg::REQ_SAMPLE: begin
               if (in_lattice) begin
                  op_in  = bdh_pkg::OP_COUNT;
                  idx_in = (!bin_zero && bin_top) ? IDX_W'(BIN_COUNT - 1) : '0;
               end else begin
                  op_in  = bdh_pkg::OP_READ;
                  idx_in = '0;
               end
            end
            bdh_pkg::REQ_CLEAR: begin
               op_in  = bdh_pkg::OP_CLEAR;
               idx_in = '0;
            end
            default: begin
               op_in  = bdh_pkg::OP_READ;
               idx_in = sel_idx;
            end
         endcase
      end else if (state_ff == bdh_pkg::FR_DIV) begin
         rem_in = div_ge ? rem_ff - dsh_ff : rem_ff;
         dsh_in = dsh_ff >> 1;
         quo_in = IDX_W'({quo_ff, div_ge});
         cnt_in = cnt_ff - 1'b1;
         idx_in = quo_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= bdh_pkg::FR_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff      <= op_in;
      idx_ff     <= idx_in;
      at_low_ff  <= at_low_in;
      at_high_ff <= at_high_in;
      rem_ff     <= rem_in;
      dsh_ff     <= dsh_in;
      quo_ff     <= quo_in;
      cnt_ff     <= cnt_in;
   end

   assign push_entry = '{op: op_ff, at_low: at_low_ff, at_high: at_high_ff};
   assign push_idx   = idx_ff;

endmodule

// ----- rtl/core/bdh_queue.sv -----
// Two-entry queue between the front and back ends of the histogram.
// Depends on bdh_pkg for its depth.
`timescale 1ns / 1ps

module bdh_queue #(
   parameter int WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  logic [WIDTH-1:0] push_data,
   output logic             pop_valid,
   input  logic             pop_ready,
   output logic [WIDTH-1:0] pop_data
);

   localparam int PTR_W = $clog2(bdh_pkg::QUEUE_DEPTH);
   localparam int CNT_W = $clog2(bdh_pkg::QUEUE_DEPTH + 1);

   logic [WIDTH-1:0] slot_ff [bdh_pkg::QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] fill_ff, fill_in;
   logic             do_push, do_pop;

   assign push_ready = fill_ff != CNT_W'(bdh_pkg::QUEUE_DEPTH);
   assign pop_valid  = fill_ff != '0;
   assign pop_data   = slot_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_push && !do_pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ----- rtl/core/bdh_back.sv -----
// Back end: bin count memory with read-modify-write, the three totals, and the
// result register. Depends on bdh_pkg.
`timescale 1ns / 1ps

module bdh_back #(
   parameter int BIN_COUNT   = 20,
   parameter int COUNT_WIDTH = 40
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         pop_valid,
   output logic                         pop_ready,
   input  bdh_pkg::entry_type           pop_entry,
   input  logic [$clog2(BIN_COUNT)-1:0] pop_idx,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [$clog2(BIN_COUNT)-1:0] out_idx,
   output logic                         out_counted,
   output logic [COUNT_WIDTH-1:0]       out_bin,
   output logic [COUNT_WIDTH-1:0]       out_total,
   output logic [COUNT_WIDTH-1:0]       out_low,
   output logic [COUNT_WIDTH-1:0]       out_high
);

   localparam int IDX_W = $clog2(BIN_COUNT);
   localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};

   logic [COUNT_WIDTH-1:0] bin_mem [BIN_COUNT];

   bdh_pkg::back_state_type state_ff, state_in;
   bdh_pkg::entry_type      entry_ff;
   logic [IDX_W-1:0]        idx_ff;
   logic [COUNT_WIDTH-1:0]  rd_ff;
   logic [BIN_COUNT-1:0]    valid_ff, valid_in;
   logic [COUNT_WIDTH-1:0]  total_ff, total_in;
   logic [COUNT_WIDTH-1:0]  low_ff, low_in;
   logic [COUNT_WIDTH-1:0]  high_ff, high_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [IDX_W-1:0]        out_idx_ff, out_idx_in;
   logic                    out_counted_ff, out_counted_in;
   logic [COUNT_WIDTH-1:0]  out_bin_ff, out_bin_in;

   logic                    take, is_count, bin_wr;
   logic [COUNT_WIDTH-1:0]  cur_bin, new_bin;

   assign take     = pop_valid && pop_ready;
   assign is_count = entry_ff.op == bdh_pkg::OP_COUNT;
   assign cur_bin  = valid_ff[idx_ff] ? rd_ff : '0;
   assign new_bin  = (is_count && cur_bin != CNT_MAX) ? cur_bin + 1'b1 : cur_bin;
   assign bin_wr   = (state_ff == bdh_pkg::BK_UPDATE) && is_count;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         bdh_pkg::BK_IDLE: begin
            if (take && pop_entry.op != bdh_pkg::OP_CLEAR) begin
               state_in = bdh_pkg::BK_UPDATE;
            end
         end
         bdh_pkg::BK_UPDATE: state_in = bdh_pkg::BK_IDLE;
         default: state_in = bdh_pkg::BK_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      case (state_ff)
         bdh_pkg::BK_IDLE: pop_ready = !rsp_valid_ff || rsp_ready;
         default: pop_ready = 1'b0;
      endcase
   end

   always_comb begin
      valid_in       = valid_ff;
      total_in       = total_ff;
      low_in         = low_ff;
      high_in        = high_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      out_idx_in     = out_idx_ff;
      out_counted_in = out_counted_ff;
      out_bin_in     = out_bin_ff;
      if (take && pop_entry.op == bdh_pkg::OP_CLEAR) begin
         valid_in       = '0;
         total_in       = '0;
         low_in         = '0;
         high_in        = '0;
         rsp_valid_in   = 1'b1;
         out_idx_in     = '0;
         out_counted_in = 1'b0;
         out_bin_in     = '0;
      end else if (state_ff == bdh_pkg::BK_UPDATE) begin
         if (is_count) begin
            valid_in[idx_ff] = 1'b1;
            if (total_ff != CNT_MAX) begin
               total_in = total_ff + 1'b1;
            end
            if (entry_ff.at_low && low_ff != CNT_MAX) begin
               low_in = low_ff + 1'b1;
            end
            if (entry_ff.at_high && high_ff != CNT_MAX) begin
               high_in = high_ff + 1'b1;
            end
         end
         rsp_valid_in   = 1'b1;
         out_idx_in     = idx_ff;
         out_counted_in = is_count;
         out_bin_in     = new_bin;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bdh_pkg::BK_IDLE;
         valid_ff     <= '0;
         total_ff     <= '0;
         low_ff       <= '0;
         high_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         valid_ff     <= valid_in;
         total_ff     <= total_in;
         low_ff       <= low_in;
         high_ff      <= high_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         entry_ff <= pop_entry;
         idx_ff   <= pop_idx;
      end
      out_idx_ff     <= out_idx_in;
      out_counted_ff <= out_counted_in;
      out_bin_ff     <= out_bin_in;
   end

   always_ff @(posedge clock) begin
      if (take) begin
         rd_ff <= bin_mem[pop_idx];
      end
      if (bin_wr) begin
         bin_mem[idx_ff] <= new_bin;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign out_idx     = out_idx_ff;
   assign out_counted = out_counted_ff;
   assign out_bin     = out_bin_ff;
   assign out_total   = total_ff;
   assign out_low     = low_ff;
   assign out_high    = high_ff;

endmodule

// ----- rtl/core/banded_density_histogram_top.sv -----
// Banded density histogram, top level: band registers, front end, queue, back end.
// Depends on bdh_pkg, bdh_front, bdh_queue and bdh_back.
//
// Request beats carry a sample, a bin read or a clear; every request gives one
// response beat with the bin index, a counted flag, that bin's count and the
// sample, at-low and at-high totals. The csr channel writes band_low (index 0)
// and band_high (index 1), Q1.16; it is always ready, and the user must write it
// only while idle, which the block itself does not enforce.
// A request is registered in the front end, held in the queue, read by the back
// end and written to the result register (a clear skips the read-modify-write); a
// sample strictly inside the band first gets its bin from a restoring divider
// giving one quotient bit a cycle, which holds the front end. The back end takes
// no new entry while it does the read-modify-write of the bin count memory.
// Reset clears every count (per-bin valid bits) and sets the band to 0..1.0.
// A clear request does the same for the counts.
// When the response side stalls, the result register holds, the two-entry queue
// fills and then req_tready drops; nothing is lost.
`timescale 1ns / 1ps

module banded_density_histogram_top #(
   parameter int BIN_COUNT   = 20,
   parameter int COUNT_WIDTH = 40
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // density [16:0], bin_select [21:17], zero pad
   input  logic [bdh_pkg::REQ_DATA_W-1:0]     req_tdata,
   // req_type [1:0], in_lattice [2]
   input  logic [bdh_pkg::REQ_USER_W-1:0]     req_tuser,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // bin_index [4:0], bin_total [44:5], sample_total [84:45],
   // low_edge_total [124:85], high_edge_total [164:125], zero pad
   output logic [bdh_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   // was_counted [0]
   output logic                               rsp_tuser,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [bdh_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [bdh_pkg::Q_W-1:0]            csr_data
);

   localparam int IDX_W = $clog2(BIN_COUNT);
   localparam int ENT_W = $bits(bdh_pkg::entry_type);
   localparam int QD_W  = ENT_W + IDX_W;
   localparam int PAD_W = bdh_pkg::RSP_DATA_W - bdh_pkg::RSP_BITS;

   logic [bdh_pkg::Q_W-1:0] band_low_ff, band_low_in;
   logic [bdh_pkg::Q_W-1:0] band_high_ff, band_high_in;

   logic                    push_valid, push_ready;
   bdh_pkg::entry_type      push_entry;
   logic [IDX_W-1:0]        push_idx;
   logic                    pop_valid, pop_ready;
   logic [QD_W-1:0]         pop_data;

   logic [IDX_W-1:0]        out_idx;
   logic                    out_counted;
   logic [COUNT_WIDTH-1:0]  out_bin, out_total, out_low, out_high;

   assign csr_ready = 1'b1;

   always_comb begin
      band_low_in  = band_low_ff;
      band_high_in = band_high_ff;
      if (csr_valid) begin
         case (csr_index)
            bdh_pkg::CSR_BAND_LOW:  band_low_in  = csr_data;
            bdh_pkg::CSR_BAND_HIGH: band_high_in = csr_data;
            default: begin
               band_low_in  = band_low_ff;
               band_high_in = band_high_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         band_low_ff  <= bdh_pkg::BAND_LOW_RESET;
         band_high_ff <= bdh_pkg::BAND_HIGH_RESET;
      end else begin
         band_low_ff  <= band_low_in;
         band_high_ff <= band_high_in;
      end
   end

   bdh_front #(
      .BIN_COUNT (BIN_COUNT)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_tvalid),
      .req_ready  (req_tready),
      .req_code   (req_tuser[bdh_pkg::REQ_CODE_W-1:0]),
      .in_lattice (req_tuser[bdh_pkg::REQ_CODE_W]),
      .density    (req_tdata[bdh_pkg::Q_W-1:0]),
      .bin_select (req_tdata[bdh_pkg::Q_W+bdh_pkg::SEL_W-1:bdh_pkg::Q_W]),
      .band_low   (band_low_ff),
      .band_high  (band_high_ff),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_entry (push_entry),
      .push_idx   (push_idx)
   );

   bdh_queue #(
      .WIDTH (QD_W)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  ({push_idx, push_entry}),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   bdh_back #(
      .BIN_COUNT   (BIN_COUNT),
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .pop_valid   (pop_valid),
      .pop_ready   (pop_ready),
      .pop_entry   (bdh_pkg::entry_type'(pop_data[ENT_W-1:0])),
      .pop_idx     (pop_data[QD_W-1:ENT_W]),
      .rsp_valid   (rsp_tvalid),
      .rsp_ready   (rsp_tready),
      .out_idx     (out_idx),
      .out_counted (out_counted),
      .out_bin     (out_bin),
      .out_total   (out_total),
      .out_low     (out_low),
      .out_high    (out_high)
   );

   assign rsp_tdata = {
      {PAD_W{1'b0}},
      bdh_pkg::OUT_CNT_W'(out_high),
      bdh_pkg::OUT_CNT_W'(out_low),
      bdh_pkg::OUT_CNT_W'(out_total),
      bdh_pkg::OUT_CNT_W'(out_bin),
      bdh_pkg::OUT_IDX_W'(out_idx)
   };
   assign rsp_tuser = out_counted;

endmodule
